### sv/assert_macros.svh
// assertion macros used by the hash controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define FXF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fxf assertion failed");

// condition in one cycle implies a condition in the next cycle
`define FXF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fxf assertion failed");

`endif

### sv/fxf_pkg.sv
// package: constants, command and status types of the fmix64 xor fold hash
`default_nettype none

package fxf_pkg;

    localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned MIX_SHIFT   = 33;
    localparam int unsigned GROUP_BYTES = 8;
    localparam int unsigned COUNT_W     = $clog2(GROUP_BYTES);
    localparam logic [COUNT_W-1:0] LAST_SLOT = COUNT_W'(GROUP_BYTES - 1);

    // partial product selected for one multiplier step
    typedef enum logic [1:0] {
        MUL_LL,
        MUL_LH,
        MUL_HL
    } mul_step_t;

    // which finaliser constant the multiplier uses
    typedef enum logic {
        CONST_A,
        CONST_B
    } mul_const_t;

    typedef struct packed {
        logic       load;       // byte transfer of a non-empty item
        logic       load_mix;   // that byte closes a word
        logic       clear;      // empty message: clear packing, accumulator and result, emit zero
        logic       mul_en;
        mul_step_t  mul_step;
        mul_const_t mul_const;
        logic       xs_en;      // xor-shift product back into the mix word
        logic       fold_en;    // final xor-shift and fold into accumulator
        logic       fold_last;  // fold ends the message
    } cmd_t;

    typedef struct packed {
        logic group_full;       // seven bytes held, next byte closes the word
    } status_t;

    function automatic logic [63:0] xor_shift(input logic [63:0] x);
        return x ^ (x >> MIX_SHIFT);
    endfunction

endpackage

`default_nettype wire

### sv/fxf_datapath.sv
// datapath: word packing, shared 32x32 multiplier, accumulator and result register
`default_nettype none

module fxf_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      data_byte,
    input  wire fxf_pkg::cmd_t   cmd,
    output fxf_pkg::status_t     status,
    output logic [63:0]          hash_value
);

    logic [63:0]                 word_reg, word_next;
    logic [fxf_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]                 acc_reg, acc_next;
    logic [63:0]                 x_reg, x_next;
    logic [63:0]                 prod_reg, prod_next;
    logic [63:0]                 out_reg, out_next;

    logic [63:0] word_new;
    logic [63:0] mul_const;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mul_prod;
    logic [63:0] mixed;

    assign word_new  = {word_reg[55:0], data_byte};
    assign mul_const = (cmd.mul_const == fxf_pkg::CONST_B) ? fxf_pkg::MIX_MUL_B
                                                           : fxf_pkg::MIX_MUL_A;
    assign op_a      = (cmd.mul_step == fxf_pkg::MUL_HL) ? x_reg[63:32] : x_reg[31:0];
    assign op_b      = (cmd.mul_step == fxf_pkg::MUL_LH) ? mul_const[63:32]
                                                         : mul_const[31:0];
    assign mul_prod  = op_a * op_b;
    assign mixed     = fxf_pkg::xor_shift(prod_reg);

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        prod_next = prod_reg;
        out_next  = out_reg;

        if (cmd.clear)
        begin
            word_next = '0;
            cnt_next  = '0;
            acc_next  = '0;
            out_next  = '0;
        end
        else if (cmd.load)
        begin
            if (cmd.load_mix)
            begin
                x_next    = fxf_pkg::xor_shift(word_new);
                word_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                word_next = word_new;
                cnt_next  = cnt_reg + {{(fxf_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
        end

        // low 64 bits of the product from three 32x32 partial products
        if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                fxf_pkg::MUL_LL: prod_next = mul_prod;
                default:         prod_next = prod_reg + {mul_prod[31:0], 32'h0};
            endcase
        end

        if (cmd.xs_en)
        begin
            x_next = mixed;
        end

        if (cmd.fold_en)
        begin
            if (cmd.fold_last)
            begin
                out_next = acc_reg ^ mixed;
                acc_next = '0;
            end
            else
            begin
                acc_next = acc_reg ^ mixed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign status.group_full = (cnt_reg == fxf_pkg::LAST_SLOT);
    assign hash_value        = out_reg;

endmodule

`default_nettype wire

### sv/fxf_controller.sv
// controller: handshakes and sequencing of the two finaliser multiplies
`default_nettype none

`include "assert_macros.svh"

module fxf_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             last_byte,
    input  wire logic             empty_message,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire fxf_pkg::status_t status,
    output fxf_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_XSA,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_FOLD
    } state_t;

    state_t state_reg, state_next;
    logic   last_pend_reg, last_pend_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer;
    logic   mix_needed;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer    = in_valid && in_ready;
    assign mix_needed = last_byte || status.group_full;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd           = '0;
        cmd.mul_step  = fxf_pkg::MUL_LL;
        cmd.mul_const = fxf_pkg::CONST_A;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (empty_message)
                    begin
                        cmd.clear      = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load     = 1'b1;
                        cmd.load_mix = mix_needed;
                        if (mix_needed)
                        begin
                            last_pend_next = last_byte;
                            state_next     = ST_MA0;
                        end
                    end
                end
            end
            ST_MA0:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_MA1;
            end
            ST_MA1:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = fxf_pkg::MUL_LH;
                state_next   = ST_MA2;
            end
            ST_MA2:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = fxf_pkg::MUL_HL;
                state_next   = ST_XSA;
            end
            ST_XSA:
            begin
                cmd.xs_en  = 1'b1;
                state_next = ST_MB0;
            end
            ST_MB0:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_const = fxf_pkg::CONST_B;
                state_next    = ST_MB1;
            end
            ST_MB1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_step  = fxf_pkg::MUL_LH;
                cmd.mul_const = fxf_pkg::CONST_B;
                state_next    = ST_MB2;
            end
            ST_MB2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_step  = fxf_pkg::MUL_HL;
                cmd.mul_const = fxf_pkg::CONST_B;
                state_next    = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold_en   = 1'b1;
                cmd.fold_last = last_pend_reg;
                if (last_pend_reg)
                begin
                    out_valid_next = 1'b1;
                end
                last_pend_next = 1'b0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FXF_ASSERT_NEXT(a_mix_start, clk, rst_n, in_xfer && !empty_message && mix_needed, state_reg == ST_MA0)
    `FXF_ASSERT_NEXT(a_last_result, clk, rst_n, state_reg == ST_FOLD && last_pend_reg, out_valid_reg && state_reg == ST_IDLE)
    `FXF_ASSERT_NEXT(a_empty_result, clk, rst_n, in_xfer && empty_message, out_valid_reg && state_reg == ST_IDLE)

endmodule

`default_nettype wire

### sv/fmix64_xor_fold_hash.sv
// top level of the fmix64 xor fold hash: controller and datapath
`default_nettype none

// Byte-stream hash: bytes arrive one per input transfer and are packed
// big-endian into 64-bit words, a short final group right-aligned with
// zeros above. Each word goes through the 64-bit Murmur3 finaliser and the
// results are xor-folded; the hash comes out as one output transfer on the
// byte marked last_byte, after which all state is clear for the next
// message. An item with empty_message set discards any pending bytes and
// gives a hash of 0. A byte that does not close a word is only packed;
// the eighth byte of a word, or the last byte, also runs the finaliser,
// whose two 64-bit multiplies each run as three partial products
// through one shared 32x32 multiplier, with a state for the middle
// xor-shift and one for the fold; no further byte is taken meanwhile.
// An empty message result appears the cycle after its transfer, a hash
// the cycle after the fold. The result sits in an output register, and
// the next byte is taken while it waits, provided the output transfer
// takes place in that same cycle or the slot is empty.

module fmix64_xor_fold_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic        empty_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      hash_value
);

    // command and status between sequencer and datapath
    fxf_pkg::cmd_t    cmd;
    fxf_pkg::status_t status;

    fxf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .cmd        (cmd),
        .status     (status),
        .hash_value (hash_value)
    );

    fxf_controller u_controller (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .last_byte     (last_byte),
        .empty_message (empty_message),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .cmd           (cmd)
    );

endmodule

`default_nettype wire
